// ----- rtl/core/mi3_pkg.sv -----
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int unsigned ElemW = 32;
	localparam int unsigned ProdW = 64;
	localparam int unsigned AdjW  = 65;
	localparam int unsigned TermW = 97;
	localparam int unsigned DetW  = 99;
	localparam int unsigned VolW  = 48;
	localparam int unsigned QW    = 32;
	localparam int unsigned NElem = 9;

	localparam logic [QW-1:0] QMaxPos = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] QMaxNeg = 32'h8000_0000;

	// cofactor k = m[CofP]*m[CofQ] - m[CofR]*m[CofS]
	localparam int unsigned CofP [NElem] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
	localparam int unsigned CofQ [NElem] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
	localparam int unsigned CofR [NElem] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
	localparam int unsigned CofS [NElem] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

	typedef logic signed [ElemW-1:0] elem_t;

	typedef struct packed {
		logic            neg;
		logic            ovf;
		logic [AdjW-1:0] mag;
	} lane_in_t;

endpackage

// ----- rtl/core/mi3_front.sv -----
`timescale 1ns / 1ps
module mi3_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  mi3_pkg::elem_t                 m [mi3_pkg::NElem],
	output logic                           out_vld,
	output logic [mi3_pkg::DetW-1:0]       det_mag,
	output logic                           det_zero,
	output logic [mi3_pkg::VolW-1:0]       vol,
	output mi3_pkg::lane_in_t              lane [mi3_pkg::NElem]
);

	localparam int unsigned N  = mi3_pkg::NElem;
	localparam int unsigned PW = mi3_pkg::ProdW;
	localparam int unsigned AW = mi3_pkg::AdjW;
	localparam int unsigned TW = mi3_pkg::TermW;
	localparam int unsigned DW = mi3_pkg::DetW;

	logic [5:0] vld_q;

	logic signed [PW-1:0] pp_s1 [N];
	logic signed [PW-1:0] pn_s1 [N];
	mi3_pkg::elem_t       a_s1  [3];
	logic signed [AW-1:0] adj_s2 [N];
	mi3_pkg::elem_t       a_s2  [3];
	logic signed [AW-1:0] adj_s3 [N];
	logic signed [AW-1:0] plo_s3 [3];
	logic signed [AW-1:0] phi_s3 [3];
	logic signed [AW-1:0] adj_s4 [N];
	logic signed [TW-1:0] term_s4 [3];
	logic signed [AW-1:0] adj_s5 [N];
	logic signed [DW-1:0] det_s5;
	logic [DW-1:0]        dmag;
	logic [AW-1:0]        amag [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				pp_s1[k] <= m[mi3_pkg::CofP[k]] * m[mi3_pkg::CofQ[k]];
				pn_s1[k] <= m[mi3_pkg::CofR[k]] * m[mi3_pkg::CofS[k]];
				adj_s2[k] <= {pp_s1[k][PW-1], pp_s1[k]} - {pn_s1[k][PW-1], pn_s1[k]};
				adj_s3[k] <= adj_s2[k];
				adj_s4[k] <= adj_s3[k];
				adj_s5[k] <= adj_s4[k];
			end
			for (int j = 0; j < 3; j++) begin
				a_s1[j] <= m[j];
				a_s2[j] <= a_s1[j];
				plo_s3[j] <= a_s2[j] * $signed({1'b0, adj_s2[3*j][31:0]});
				phi_s3[j] <= a_s2[j] * $signed(adj_s2[3*j][AW-1:32]);
				term_s4[j] <= {phi_s3[j], 32'd0} + {{32{plo_s3[j][AW-1]}}, plo_s3[j]};
			end
			det_s5 <= {{2{term_s4[0][TW-1]}}, term_s4[0]}
				+ {{2{term_s4[1][TW-1]}}, term_s4[1]}
				+ {{2{term_s4[2][TW-1]}}, term_s4[2]};
		end
	end

	always_comb begin
		dmag = det_s5[DW-1] ? (~det_s5 + DW'(1)) : det_s5;
		for (int k = 0; k < N; k++) begin
			amag[k] = adj_s5[k][AW-1] ? (~adj_s5[k] + AW'(1)) : adj_s5[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_mag  <= dmag;
			det_zero <= (det_s5 == '0);
			vol      <= (dmag[DW-1:80] != '0) ? '1 : dmag[79:32];
			for (int k = 0; k < N; k++) begin
				lane[k].neg <= adj_s5[k][AW-1] ^ det_s5[DW-1];
				lane[k].ovf <= {{(DW-AW){1'b0}}, amag[k]} >= dmag;
				lane[k].mag <= amag[k];
			end
		end
	end

	assign out_vld = vld_q[5];

endmodule

// ----- rtl/core/mi3_div_lane.sv -----
`timescale 1ns / 1ps
module mi3_div_lane (
	input  logic                       clk,
	input  logic                       en,
	input  mi3_pkg::lane_in_t          din,
	input  logic [mi3_pkg::DetW-1:0]   d,
	output logic [mi3_pkg::QW-1:0]     q_sat
);

	localparam int unsigned QW = mi3_pkg::QW;
	localparam int unsigned DW = mi3_pkg::DetW;

	logic [DW-1:0] r_s   [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] q_s   [QW];
	logic          neg_s [QW];
	logic          ovf_s [QW];
	logic [QW-1:0] q;
	logic [QW-1:0] qn;

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic          neg_in;
		logic          ovf_in;
		logic [DW:0]   r2;
		logic [DW:0]   diff;
		if (j == 0) begin : g_head
			assign r_in   = {{(DW-mi3_pkg::AdjW){1'b0}}, din.mag};
			assign d_in   = d;
			assign q_in   = '0;
			assign neg_in = din.neg;
			assign ovf_in = din.ovf;
		end else begin : g_tail
			assign r_in   = r_s[j-1];
			assign d_in   = d_s[j-1];
			assign q_in   = q_s[j-1];
			assign neg_in = neg_s[j-1];
			assign ovf_in = ovf_s[j-1];
		end
		assign r2   = {r_in, 1'b0};
		assign diff = r2 - {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]   <= diff[DW] ? r2[DW-1:0] : diff[DW-1:0];
				q_s[j]   <= {q_in[QW-2:0], ~diff[DW]};
				d_s[j]   <= d_in;
				neg_s[j] <= neg_in;
				ovf_s[j] <= ovf_in;
			end
		end
	end

	assign q  = q_s[QW-1];
	assign qn = ~q + QW'(1);

	always_comb begin
		if (neg_s[QW-1]) begin
			q_sat = (ovf_s[QW-1] || q > mi3_pkg::QMaxNeg) ? mi3_pkg::QMaxNeg : qn;
		end else begin
			q_sat = (ovf_s[QW-1] || q[QW-1]) ? mi3_pkg::QMaxPos : q;
		end
	end

endmodule

// ----- rtl/core/matrix_inverse_3x3_top.sv -----
`timescale 1ns / 1ps
// channel | signals                              | direction
// in      | in_valid, in_ready, m00 .. m22       | matrix in
// out     | out_valid, out_ready, inv00 .. inv22,| result out
//         | cell_volume, singular                |
// One matrix per cycle while the skid register is empty; the path has 6 cofactor/determinant stages,
// 32 restoring divide stages per lane and one output register.
// The nine divider lanes are pipelined, one quotient bit per stage.
// arst_n clears all valid bits; data registers are not reset.
// A stalled result drops into a skid register; in_ready is that register's empty flag.
module matrix_inverse_3x3_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
	output logic [47:0] cell_volume,
	output logic        singular
);

	localparam int unsigned N  = mi3_pkg::NElem;
	localparam int unsigned QW = mi3_pkg::QW;
	localparam int unsigned VW = mi3_pkg::VolW;
	localparam int unsigned RW = N*QW + VW + 1;

	logic                  en;
	mi3_pkg::elem_t        m [N];
	logic                  f_vld;
	logic [mi3_pkg::DetW-1:0] det_mag;
	logic                  det_zero;
	logic [VW-1:0]         vol;
	mi3_pkg::lane_in_t     lane [N];
	logic [QW-1:0]         q [N];

	logic [QW-1:0] vld_s;
	logic          zero_s [QW];
	logic [VW-1:0] vol_s  [QW];

	logic [RW-1:0] res;
	logic          res_vld;
	logic [RW-1:0] out_q;
	logic [RW-1:0] skid_q;
	logic          skid_vld_q;

	assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
	assign en = !skid_vld_q;
	assign in_ready = en;

	mi3_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.m       (m),
		.out_vld (f_vld),
		.det_mag (det_mag),
		.det_zero(det_zero),
		.vol     (vol),
		.lane    (lane)
	);

	for (genvar k = 0; k < N; k++) begin : g_lane
		mi3_div_lane u_lane (
			.clk  (clk),
			.en   (en),
			.din  (lane[k]),
			.d    (det_mag),
			.q_sat(q[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-2:0], f_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= det_zero;
			vol_s[0]  <= vol;
			for (int j = 1; j < QW; j++) begin
				zero_s[j] <= zero_s[j-1];
				vol_s[j]  <= vol_s[j-1];
			end
		end
	end

	always_comb begin
		res_vld = vld_s[QW-1];
		for (int k = 0; k < N; k++) begin
			res[RW-1-k*QW -: QW] = zero_s[QW-1] ? '0 : q[k];
		end
		res[VW:1] = zero_s[QW-1] ? '0 : vol_s[QW-1];
		res[0]    = zero_s[QW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_vld_q) begin
				out_valid  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_valid <= res_vld;
			end
		end else if (en && res_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (en && res_vld) begin
			skid_q <= res;
		end
	end

	assign inv00       = out_q[RW-1 -: QW];
	assign inv01       = out_q[RW-1-1*QW -: QW];
	assign inv02       = out_q[RW-1-2*QW -: QW];
	assign inv10       = out_q[RW-1-3*QW -: QW];
	assign inv11       = out_q[RW-1-4*QW -: QW];
	assign inv12       = out_q[RW-1-5*QW -: QW];
	assign inv20       = out_q[RW-1-6*QW -: QW];
	assign inv21       = out_q[RW-1-7*QW -: QW];
	assign inv22       = out_q[RW-1-8*QW -: QW];
	assign cell_volume = out_q[VW:1];
	assign singular    = out_q[0];

endmodule

// ----- bench/mi3_checker.sv -----
`timescale 1ns / 1ps
module mi3_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
	input  logic [47:0] cell_volume,
	input  logic        singular,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [31:0] inv [9];
		logic [47:0] vol;
		logic        sing;
	} inverse_t;

	inverse_t inverse_q[$];

	function automatic logic [31:0] quotient_sat(logic signed [127:0] adj,
			logic signed [127:0] det);
		logic               neg;
		logic [127:0] num, den, q;
		neg = adj[127] ^ det[127];
		num = (adj[127] ? -adj : adj) << 32;
		den = det[127] ? -det : det;
		q = num / den;
		if (neg) begin
			if (q > 128'h8000_0000) return mi3_pkg::QMaxNeg;
			return 32'(-q);
		end
		if (q > 128'h7FFF_FFFF) return mi3_pkg::QMaxPos;
		return q[31:0];
	endfunction

	function automatic inverse_t invert(logic [31:0] e [9]);
		inverse_t r;
		logic signed [127:0] a [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] det;
		logic [127:0] mag, v;
		for (int i = 0; i < 9; i++) a[i] = 128'(signed'(e[i]));
		adj[0] = a[4]*a[8] - a[5]*a[7];
		adj[1] = a[7]*a[2] - a[8]*a[1];
		adj[2] = a[1]*a[5] - a[2]*a[4];
		adj[3] = a[5]*a[6] - a[3]*a[8];
		adj[4] = a[8]*a[0] - a[6]*a[2];
		adj[5] = a[2]*a[3] - a[0]*a[5];
		adj[6] = a[3]*a[7] - a[4]*a[6];
		adj[7] = a[6]*a[1] - a[7]*a[0];
		adj[8] = a[0]*a[4] - a[1]*a[3];
		det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
		if (det == 0) begin
			for (int i = 0; i < 9; i++) r.inv[i] = '0;
			r.vol = '0;
			r.sing = 1'b1;
			return r;
		end
		for (int i = 0; i < 9; i++) r.inv[i] = quotient_sat(adj[i], det);
		mag = det[127] ? -det : det;
		v = mag >> 32;
		r.vol = (v > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
		r.sing = 1'b0;
		return r;
	endfunction

	assign pending = inverse_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		logic [31:0] e [9];
		logic [31:0] got [9];
		inverse_t x;
		if (arst_n && in_valid && in_ready) begin
			e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			inverse_q.push_back(invert(e));
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
			if (inverse_q.size() == 0) begin
				$display("%0t: unexpected result", $time);
				fail_count++;
			end else begin
				x = inverse_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== x.inv[i]) begin
						$display("%0t: inv[%0d] expected %h actual %h", $time, i,
							x.inv[i], got[i]);
						fail_count++;
					end
				if (cell_volume !== x.vol) begin
					$display("%0t: cell_volume expected %h actual %h", $time, x.vol,
						cell_volume);
					fail_count++;
				end
				if (singular !== x.sing) begin
					$display("%0t: singular expected %b actual %b", $time, x.sing,
						singular);
					fail_count++;
				end
			end
		end
	end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] m [9];
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] inv [9];
	logic [47:0] cell_volume;
	logic        singular;
	int          fail_count, pending;
	int          hold_off = 0;
	longint      cycles = 0;

	initial for (int i = 0; i < 9; i++) m[i] = '0;

	always #2 clk = ~clk;

	matrix_inverse_3x3_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
		.m20(m[6]), .m21(m[7]), .m22(m[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
		.inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
		.cell_volume(cell_volume), .singular(singular)
	);

	mi3_checker i_chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
		.m20(m[6]), .m21(m[7]), .m22(m[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
		.inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
		.cell_volume(cell_volume), .singular(singular),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] pick_elem();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'h0001_0000;
			4: return 32'hFFFF_0000;
			5: return $urandom_range(0, 3);
			6: return 32'(signed'(16'($urandom())));
			7: return 32'($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send(logic [31:0] e [9]);
		for (int i = 0; i < 9; i++) m[i] <= e[i];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver: random stalls, with one long hold-off requested by the sender side
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 30) == 0 ? 0 : 1)
				&& ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] e [9];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: identity, zeros, extremes, singular, saturation cases
		e = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000}; send(e);
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send(e);
		for (int i = 0; i < 9; i++) e[i] = 32'h8000_0000; send(e);
		for (int i = 0; i < 9; i++) e[i] = 32'h7FFF_FFFF; send(e);
		e = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000}; send(e);
		e = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF}; send(e);
		e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send(e);
		e = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1};
		send(e);
		e = '{32'h2_0000, 32'h1_0000, 0, 32'h4_0000, 32'h2_0000, 0, 0, 0, 32'h1_0000};
		send(e);
		e = '{32'hFFFF_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000}; send(e);
		e = '{0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0}; send(e);
		e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
			32'h7FFF_FFFF, 0};
		send(e);
		e = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1}; send(e);
		// pause until drained
		idle(1);
		while (pending != 0) @(posedge clk);
		// fill the pipeline against a long receiver hold-off
		hold_off <= 200;
		for (int n = 0; n < 120; n++) begin
			for (int i = 0; i < 9; i++) e[i] = pick_elem();
			send(e);
		end
		for (int n = 0; n < 1000; n++) begin
			for (int i = 0; i < 9; i++) e[i] = pick_elem();
			// force some singular matrices: copy a row
			if ($urandom_range(0, 9) == 0)
				for (int i = 0; i < 3; i++) e[6 + i] = e[i];
			send(e);
			idle(gap_len());
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0 && !out_valid) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
